// ===== hdl/scc_pkg.sv =====
// package with the shared types and constants of the sprite block cell composer
`default_nettype none
package scc_pkg;

  // kind of an input word, carried on tuser
  typedef enum logic {
    ACT_HEADER = 1'b0,
    ACT_TILE   = 1'b1
  } action_e;

  localparam int unsigned CODE_W      = 14;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam logic [15:0] CODE_MASK   = 16'h3FFF;

  // flag byte bit positions
  localparam int unsigned FLAG_SEQ    = 0;
  localparam int unsigned FLAG_FLIPY  = 2;
  localparam int unsigned FLAG_FLIPX  = 3;
  localparam int unsigned FLAG_PAL_LO = 4;

  // one placed-tile job handed from front to back
  typedef struct packed {
    logic signed [7:0]  x_off;
    logic signed [7:0]  y_off;
    logic signed [7:0]  dx;
    logic signed [7:0]  dy;
    logic [CODE_W-1:0]  code;
    logic               chained;
    logic               flip_x;
    logic               flip_y;
    logic [2:0]         palette;
  } job_t;

  // push side of the job queue
  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

endpackage
`default_nettype wire

// ===== hdl/scc_front.sv =====
// front end: accepts header and tile words, tracks the block and issues tile jobs
`default_nettype none
module scc_front #(
  parameter int unsigned MAX_TILES = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [111:0]      s_axis_tdata,
  input  wire logic              s_axis_tuser,
  input  wire logic              q_full_i,
  output scc_pkg::job_push_t     push_o
);
  import scc_pkg::*;

  localparam logic [7:0] MaxTiles = 8'(MAX_TILES);

  logic             active_q, active_d;
  logic [7:0]       flags_q, flags_d;
  logic [7:0]       xoff_q, xoff_d;
  logic [7:0]       yoff_q, yoff_d;
  logic [31:0]      mask_q, mask_d;
  logic [IDX_W-1:0] total_q, total_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0]      seq_q, seq_d;

  logic             accept;
  logic             is_tile;
  logic [7:0]       count;
  logic             chained;
  logic [IDX_W-1:0] idx_inc;

  assign s_axis_tready = ~q_full_i;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign is_tile       = (action_e'(s_axis_tuser) == ACT_TILE);
  assign count         = s_axis_tdata[31:24];
  assign chained       = mask_q[5'd31 - idx_q[4:0]];
  assign idx_inc       = idx_q + 1'b1;

  // block state update and job payload
  always_comb begin
    active_d = active_q;
    flags_d  = flags_q;
    xoff_d   = xoff_q;
    yoff_d   = yoff_q;
    mask_d   = mask_q;
    total_d  = total_q;
    idx_d    = idx_q;
    seq_d    = seq_q;
    push_o.valid = 1'b0;
    push_o.job.x_off   = xoff_q;
    push_o.job.y_off   = yoff_q;
    push_o.job.dx      = s_axis_tdata[87:80];
    push_o.job.dy      = s_axis_tdata[95:88];
    push_o.job.code    = flags_q[FLAG_SEQ] ? CODE_W'(seq_q & CODE_MASK)
                                           : CODE_W'(s_axis_tdata[111:96] & CODE_MASK);
    push_o.job.chained = chained;
    push_o.job.flip_x  = flags_q[FLAG_FLIPX];
    push_o.job.flip_y  = flags_q[FLAG_FLIPY];
    push_o.job.palette = flags_q[FLAG_PAL_LO +: 3];
    if (accept) begin
      if (!is_tile) begin
        if (count == 8'd0 || count > MaxTiles) begin
          active_d = 1'b0;
        end else begin
          active_d = 1'b1;
          xoff_d   = s_axis_tdata[7:0];
          yoff_d   = s_axis_tdata[15:8];
          flags_d  = s_axis_tdata[23:16];
          total_d  = count[IDX_W-1:0];
          mask_d   = s_axis_tdata[63:32];
          seq_d    = s_axis_tdata[79:64];
          idx_d    = '0;
        end
      end else if (active_q && idx_q < total_q) begin
        push_o.valid = 1'b1;
        idx_d = idx_inc;
        if (idx_inc >= total_q) active_d = 1'b0;
        if (flags_q[FLAG_SEQ]) seq_d = seq_q + (chained ? 16'd2 : 16'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      flags_q  <= '0;
      xoff_q   <= '0;
      yoff_q   <= '0;
      mask_q   <= '0;
      total_q  <= '0;
      idx_q    <= '0;
      seq_q    <= '0;
    end else begin
      active_q <= active_d;
      flags_q  <= flags_d;
      xoff_q   <= xoff_d;
      yoff_q   <= yoff_d;
      mask_q   <= mask_d;
      total_q  <= total_d;
      idx_q    <= idx_d;
      seq_q    <= seq_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/scc_queue.sv =====
// small job queue between front and back
`default_nettype none
module scc_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  scc_pkg::job_push_t      push_i,
  output logic                    full_o,
  output logic                    valid_o,
  output scc_pkg::job_t           job_o,
  input  wire logic               pop_i
);
  import scc_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_pop;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_pop  = pop_i & valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.valid) mem_q[wr_q] <= push_i.job;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.valid) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (push_i.valid && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (!push_i.valid && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/scc_back.sv =====
// back end: places the cell and holds it in the output register
`default_nettype none
module scc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  scc_pkg::job_t      job_i,
  output logic               pop_o,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [39:0]        m_axis_tdata
);
  import scc_pkg::*;

  logic              vld_q;
  logic [39:0]       data_q, data_d;
  logic signed [8:0] x;
  logic signed [9:0] y;

  assign pop_o = job_valid_i & (~vld_q | m_axis_tready);

  // cell position
  always_comb begin
    x = 9'(job_i.x_off) + 9'(job_i.dx);
    y = 10'sd8 - (10'(job_i.y_off) + 10'(job_i.dy)) + (job_i.chained ? 10'sd8 : 10'sd0);
    data_d = {1'b0, job_i.palette, job_i.flip_y, job_i.flip_x, job_i.chained,
              job_i.code, y, x};
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (pop_o) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) data_q <= data_d;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;

endmodule
`default_nettype wire

// ===== hdl/sprite_block_cell_composer.sv =====
// top level: one tile word in, one placed cell word out, at up to one word per cycle
// path: an accepted tile word is written into the job queue, then registered as a cell in the back output register
// throughput: one word per cycle while the job queue is not full, set by the front block counter and the back adders
// headers and dropped tiles are accepted but give no word
// a four-entry job queue lets input keep flowing while the output stalls, until the queue is full
// reset (rst_ni low, asynchronous) clears the block state, the queue and the output valid
`default_nettype none
module sprite_block_cell_composer #(
  parameter int unsigned MAX_TILES = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // x_off[7:0] y_off[15:8] flags[23:16] count[31:24] chain_mask[63:32]
  // base_code[79:64] dx[87:80] dy[95:88] tile_code[111:96]
  input  wire logic [111:0]  s_axis_tdata,
  // action
  input  wire logic          s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // cell_x[8:0] cell_y[18:9] cell_code[32:19] cell_chained[33] cell_flip_x[34]
  // cell_flip_y[35] cell_palette[38:36] zero pad[39]
  output logic [39:0]        m_axis_tdata
);
  import scc_pkg::*;

  job_push_t push;
  job_t      head;
  logic      q_full;
  logic      q_valid;
  logic      pop;

  scc_front #(.MAX_TILES(MAX_TILES)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .push_o        (push)
  );

  scc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (head),
    .pop_i   (pop)
  );

  scc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (q_valid),
    .job_i         (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire
